// ===== rtl/cart_pkg.sv =====
`timescale 1ns / 1ps
package cart_pkg;

	localparam int MAX_ENTRIES_DEF = 8;

	localparam logic [1:0] KIND_SUBMIT = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [2:0] RES_FIRST   = 3'd0;
	localparam logic [2:0] RES_FULL    = 3'd1;
	localparam logic [2:0] RES_RESEND  = 3'd2;
	localparam logic [2:0] RES_ACKED   = 3'd3;
	localparam logic [2:0] RES_TIMEOUT = 3'd4;
	localparam logic [2:0] RES_IGNORED = 3'd5;

	localparam logic [1:0] REG_OWN_SYS  = 2'd0;
	localparam logic [1:0] REG_OWN_COMP = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	localparam logic [7:0] TIMEOUT_RST = 8'd5;
	localparam logic [7:0] CNT_MAX     = 8'hFF;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic [15:0] cmd;
		logic [7:0]  tag;
		logic [7:0]  wanted;
		logic [7:0]  sent;
		logic [7:0]  age;
	} entry_t;

	typedef struct packed {
		logic [2:0]  ev;
		logic [15:0] cmd;
		logic [7:0]  tag;
		logic [7:0]  sends;
		logic [7:0]  conf;
		logic [7:0]  code;
	} result_t;

endpackage

// ===== rtl/cart_ram.sv =====
`timescale 1ns / 1ps
module cart_ram #(
	parameter int DEPTH = cart_pkg::MAX_ENTRIES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  cart_pkg::entry_t    wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output cart_pkg::entry_t    rdata
);

	cart_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/command_ack_retry_table.sv =====
`timescale 1ns / 1ps
// Submit, foreign ack, kind three: result (if any) in the cycle after accept, busy stays low.
// Own ack and tick: walk of the table, one entry per cycle through the registered memory read;
// busy for the whole walk, and no new item is accepted until busy falls.
// Walk results come at most one per cycle; the final one, flagged by last, shows as busy falls.
// The receiver cannot stall: each result shows for one cycle under strobe.
// Reset clears the entry count, output strobe and registers (timeout 5); the memory is not cleared.
module command_ack_retry_table #(
	parameter int MAX_ENTRIES = cart_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [15:0] cmd_num,
	input  logic [7:0]  payload_tag,
	input  logic [7:0]  wanted_sends,
	input  logic [7:0]  ack_target_system,
	input  logic [7:0]  ack_target_component,
	input  logic [7:0]  ack_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        strobe,
	output logic [2:0]  event_res,
	output logic [15:0] out_command_id,
	output logic [7:0]  out_payload_tag,
	output logic [7:0]  sends_done,
	output logic [7:0]  confirmation,
	output logic [7:0]  out_ack_code,
	output logic        last
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_C = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	cart_pkg::state_t  state_q, state_d;
	logic [7:0]        own_sys_q, own_comp_q, timeout_q;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     rd_q, rd_d, wr_q, wr_d;
	logic              vld_s1, issue;
	logic              ack_mode_q, ack_mode_d;
	logic              found_q, found_d;
	logic [15:0]       op_cmd_q, op_cmd_d;
	logic [7:0]        op_code_q, op_code_d;
	cart_pkg::result_t pend_q, pend_d, emit_r;
	logic              pend_v_q, pend_v_d, emit_v, emit_last;
	cart_pkg::result_t res_q;
	logic              strobe_q, last_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	cart_pkg::entry_t  mem_wdata, rdata_s1, ent;
	logic [7:0]        age_inc;
	logic              accept;

	cart_ram #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rd_q[AW-1:0]),
		.rdata (rdata_s1)
	);

	assign busy      = (state_q != cart_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign issue     = (state_q == cart_pkg::ST_WALK) && (rd_q < cnt_q);
	assign age_inc   = (rdata_s1.age < cart_pkg::CNT_MAX) ? rdata_s1.age + 8'd1 : rdata_s1.age;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		rd_d       = rd_q;
		wr_d       = wr_q;
		ack_mode_d = ack_mode_q;
		found_d    = found_q;
		op_cmd_d   = op_cmd_q;
		op_code_d  = op_code_q;
		pend_d     = pend_q;
		pend_v_d   = pend_v_q;
		emit_v     = 1'b0;
		emit_last  = 1'b0;
		emit_r     = '0;
		mem_we     = 1'b0;
		mem_waddr  = wr_q[AW-1:0];
		mem_wdata  = rdata_s1;
		ent        = rdata_s1;
		case (state_q)
			cart_pkg::ST_IDLE: begin
				if (accept) begin
					op_cmd_d  = cmd_num;
					op_code_d = ack_code;
					rd_d      = '0;
					wr_d      = '0;
					found_d   = 1'b0;
					pend_v_d  = 1'b0;
					case (kind)
						cart_pkg::KIND_SUBMIT: begin
							emit_v     = 1'b1;
							emit_last  = 1'b1;
							emit_r.cmd = cmd_num;
							emit_r.tag = payload_tag;
							if (cnt_q >= FULL_C) begin
								emit_r.ev = cart_pkg::RES_FULL;
							end else begin
								emit_r.ev        = cart_pkg::RES_FIRST;
								emit_r.sends     = 8'd1;
								mem_we           = 1'b1;
								mem_waddr        = cnt_q[AW-1:0];
								mem_wdata.cmd    = cmd_num;
								mem_wdata.tag    = payload_tag;
								mem_wdata.wanted = wanted_sends;
								mem_wdata.sent   = 8'd1;
								mem_wdata.age    = 8'd0;
								cnt_d            = cnt_q + ONE_C;
							end
						end
						cart_pkg::KIND_ACK: begin
							if (ack_target_system == own_sys_q &&
							    ack_target_component == own_comp_q) begin
								ack_mode_d = 1'b1;
								state_d    = cart_pkg::ST_WALK;
							end else begin
								emit_v      = 1'b1;
								emit_last   = 1'b1;
								emit_r.ev   = cart_pkg::RES_IGNORED;
								emit_r.cmd  = cmd_num;
								emit_r.code = ack_code;
							end
						end
						cart_pkg::KIND_TICK: begin
							ack_mode_d = 1'b0;
							state_d    = cart_pkg::ST_WALK;
						end
						default: begin
						end
					endcase
				end
			end
			cart_pkg::ST_WALK: begin
				if (issue) begin
					rd_d = rd_q + ONE_C;
				end
				if (vld_s1) begin
					logic              keep, new_v;
					cart_pkg::result_t nr;
					keep  = 1'b1;
					new_v = 1'b0;
					nr    = '0;
					if (ack_mode_q) begin
						if (!found_q && rdata_s1.cmd == op_cmd_q) begin
							found_d  = 1'b1;
							keep     = 1'b0;
							new_v    = 1'b1;
							nr.ev    = cart_pkg::RES_ACKED;
							nr.cmd   = rdata_s1.cmd;
							nr.tag   = rdata_s1.tag;
							nr.sends = rdata_s1.sent;
							nr.code  = op_code_q;
						end
					end else begin
						ent.age = age_inc;
						if (age_inc > timeout_q) begin
							new_v  = 1'b1;
							nr.cmd = rdata_s1.cmd;
							nr.tag = rdata_s1.tag;
							if (rdata_s1.sent < rdata_s1.wanted) begin
								ent.sent = (rdata_s1.sent < cart_pkg::CNT_MAX) ?
								           rdata_s1.sent + 8'd1 : rdata_s1.sent;
								ent.age  = 8'd0;
								nr.ev    = cart_pkg::RES_RESEND;
								nr.sends = ent.sent;
								nr.conf  = rdata_s1.sent;
							end else begin
								keep     = 1'b0;
								nr.ev    = cart_pkg::RES_TIMEOUT;
								nr.sends = rdata_s1.sent;
							end
						end
					end
					if (keep) begin
						mem_we    = 1'b1;
						mem_wdata = ent;
						wr_d      = wr_q + ONE_C;
					end
					if (new_v) begin
						if (pend_v_q) begin
							emit_v = 1'b1;
							emit_r = pend_q;
						end
						pend_d   = nr;
						pend_v_d = 1'b1;
					end
				end else if (!issue) begin
					state_d = cart_pkg::ST_IDLE;
					cnt_d   = wr_q;
					if (pend_v_q) begin
						emit_v    = 1'b1;
						emit_last = 1'b1;
						emit_r    = pend_q;
						pend_v_d  = 1'b0;
					end else if (ack_mode_q && !found_q) begin
						emit_v      = 1'b1;
						emit_last   = 1'b1;
						emit_r.ev   = cart_pkg::RES_IGNORED;
						emit_r.cmd  = op_cmd_q;
						emit_r.code = op_code_q;
					end
				end
			end
			default: begin
				state_d = cart_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cart_pkg::ST_IDLE;
			cnt_q      <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			vld_s1     <= 1'b0;
			ack_mode_q <= 1'b0;
			found_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
			own_sys_q  <= '0;
			own_comp_q <= '0;
			timeout_q  <= cart_pkg::TIMEOUT_RST;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			rd_q       <= rd_d;
			wr_q       <= wr_d;
			vld_s1     <= issue;
			ack_mode_q <= ack_mode_d;
			found_q    <= found_d;
			pend_v_q   <= pend_v_d;
			strobe_q   <= emit_v;
			last_q     <= emit_v && emit_last;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cart_pkg::REG_OWN_SYS:  own_sys_q  <= cfg_data;
					cart_pkg::REG_OWN_COMP: own_comp_q <= cfg_data;
					cart_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		op_cmd_q  <= op_cmd_d;
		op_code_q <= op_code_d;
		pend_q    <= pend_d;
		if (emit_v) begin
			res_q <= emit_r;
		end
	end

	assign strobe          = strobe_q;
	assign last            = last_q;
	assign event_res       = res_q.ev;
	assign out_command_id  = res_q.cmd;
	assign out_payload_tag = res_q.tag;
	assign sends_done      = res_q.sends;
	assign confirmation    = res_q.conf;
	assign out_ack_code    = res_q.code;

endmodule

// ===== rtl/cart_checker.sv =====
`timescale 1ns / 1ps
module cart_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        strobe,
	input logic [2:0]  event_res,
	input logic [7:0]  out_payload_tag,
	input logic [7:0]  sends_done,
	input logic [7:0]  confirmation,
	input logic        last
);

	a_submit_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == cart_pkg::KIND_SUBMIT |=> strobe && last &&
		(event_res == cart_pkg::RES_FIRST || event_res == cart_pkg::RES_FULL))
		else $error("submit without single result");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while idle");

	a_first_send: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && event_res == cart_pkg::RES_FIRST |-> sends_done == 8'd1 &&
		confirmation == 8'd0)
		else $error("first send fields wrong");

	a_ignored_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && event_res == cart_pkg::RES_IGNORED |-> last &&
		out_payload_tag == 8'd0 && sends_done == 8'd0)
		else $error("ignored ack fields wrong");

endmodule

bind command_ack_retry_table cart_checker u_cart_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.kind            (kind),
	.strobe          (strobe),
	.event_res       (event_res),
	.out_payload_tag (out_payload_tag),
	.sends_done      (sends_done),
	.confirmation    (confirmation),
	.last            (last)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import cart_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int unsigned SETTLE_CYCLES = MAX_ENTRIES_DEF + 4;
	localparam int unsigned QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] cmd;
		logic [7:0]  tag;
		logic [7:0]  wanted;
		logic [7:0]  tsys;
		logic [7:0]  tcomp;
		logic [7:0]  code;
	} link_item_t;

	typedef struct packed {
		result_t res;
		logic    lst;
	} outcome_t;

	typedef struct packed {
		link_item_t it;
		result_t    want;
		logic       typed;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = KIND_SUBMIT;
	logic [15:0] cmd_num = '0;
	logic [7:0]  payload_tag = '0;
	logic [7:0]  wanted_sends = '0;
	logic [7:0]  ack_target_system = '0;
	logic [7:0]  ack_target_component = '0;
	logic [7:0]  ack_code = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_OWN_SYS;
	logic [7:0]  cfg_data = '0;
	logic        strobe;
	logic [2:0]  event_res;
	logic [15:0] out_command_id;
	logic [7:0]  out_payload_tag;
	logic [7:0]  sends_done;
	logic [7:0]  confirmation;
	logic [7:0]  out_ack_code;
	logic        last;

	entry_t      slots[MAX_ENTRIES_DEF];
	int unsigned fill = 0;
	logic [7:0]  own_sys = 8'd0;
	logic [7:0]  own_comp = 8'd0;
	logic [7:0]  tmo = TIMEOUT_RST;
	outcome_t    pending_results[$];
	plan_row_t   plan[$];
	int unsigned mismatches = 0;
	int unsigned quiet = 0;

	command_ack_retry_table uut (.*);

	always #5 clk = ~clk;

	task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			flag_mismatch(what, got, want);
	endtask

	task automatic expect_result(logic [2:0] ev, logic [15:0] cmd, logic [7:0] tag,
			logic [7:0] sends, logic [7:0] conf, logic [7:0] code);
		outcome_t o;
		o.res.ev = ev;
		o.res.cmd = cmd;
		o.res.tag = tag;
		o.res.sends = sends;
		o.res.conf = conf;
		o.res.code = code;
		o.lst = 1'b0;
		pending_results = {pending_results, o};
	endtask

	task automatic drop_slot(int unsigned idx);
		for (int unsigned j = idx; j + 1 < fill; j++)
			slots[j] = slots[j + 1];
		fill--;
	endtask

	task automatic advance_table(link_item_t it);
		int unsigned i;
		int unsigned n_prior;
		bit hit;
		logic [7:0] prev;
		n_prior = pending_results.size();
		hit = 1'b0;
		case (it.kind)
			KIND_SUBMIT: begin
				if (fill >= MAX_ENTRIES_DEF) begin
					expect_result(RES_FULL, it.cmd, it.tag, 8'd0, 8'd0, 8'd0);
				end else begin
					slots[fill].cmd = it.cmd;
					slots[fill].tag = it.tag;
					slots[fill].wanted = it.wanted;
					slots[fill].sent = 8'd1;
					slots[fill].age = 8'd0;
					fill++;
					expect_result(RES_FIRST, it.cmd, it.tag, 8'd1, 8'd0, 8'd0);
				end
			end
			KIND_ACK: begin
				if (it.tsys == own_sys && it.tcomp == own_comp) begin
					for (i = 0; i < fill && !hit; i++) begin
						if (slots[i].cmd == it.cmd) begin
							expect_result(RES_ACKED, it.cmd, slots[i].tag, slots[i].sent,
								8'd0, it.code);
							drop_slot(i);
							hit = 1'b1;
						end
					end
				end
				if (!hit)
					expect_result(RES_IGNORED, it.cmd, 8'd0, 8'd0, 8'd0, it.code);
			end
			KIND_TICK: begin
				i = 0;
				while (i < fill) begin
					if (slots[i].age != CNT_MAX)
						slots[i].age = slots[i].age + 8'd1;
					if (slots[i].age > tmo) begin
						if (slots[i].sent < slots[i].wanted) begin
							prev = slots[i].sent;
							if (slots[i].sent != CNT_MAX)
								slots[i].sent = slots[i].sent + 8'd1;
							slots[i].age = 8'd0;
							expect_result(RES_RESEND, slots[i].cmd, slots[i].tag,
								slots[i].sent, prev, 8'd0);
							i++;
						end else begin
							// the next entry slides into this slot, examine it too
							expect_result(RES_TIMEOUT, slots[i].cmd, slots[i].tag,
								slots[i].sent, 8'd0, 8'd0);
							drop_slot(i);
						end
					end else begin
						i++;
					end
				end
			end
			default: ;
		endcase
		if (pending_results.size() > n_prior)
			pending_results[pending_results.size() - 1].lst = 1'b1;
	endtask

	task automatic push_item(link_item_t it, bit typed, result_t want);
		kind <= it.kind;
		cmd_num <= it.cmd;
		payload_tag <= it.tag;
		wanted_sends <= it.wanted;
		ack_target_system <= it.tsys;
		ack_target_component <= it.tcomp;
		ack_code <= it.code;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		advance_table(it);
		if (typed)
			pending_results[pending_results.size() - 1].res = want;
	endtask

	function automatic int unsigned pick_gap(bit steady);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic idle_for(int unsigned n);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// drain every expected result, then let a walk with no result finish
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OWN_SYS:  own_sys = val;
			REG_OWN_COMP: own_comp = val;
			REG_TIMEOUT:  tmo = val;
			default: ;
		endcase
	endtask

	task automatic write_config(logic [7:0] sys, logic [7:0] comp, logic [7:0] tout);
		write_reg(REG_OWN_SYS, sys);
		write_reg(REG_OWN_COMP, comp);
		write_reg(REG_TIMEOUT, tout);
		cfg_valid <= 1'b0;
	endtask

	task automatic roll_item(output link_item_t it, input int unsigned tick_pct);
		int unsigned r;
		it.cmd = 16'($urandom);
		it.tag = 8'($urandom);
		it.wanted = 8'($urandom);
		it.tsys = 8'($urandom);
		it.tcomp = 8'($urandom);
		it.code = 8'($urandom);
		if ($urandom_range(0, 2) == 0)
			it.cmd = 16'($urandom_range(0, 3));
		if ($urandom_range(0, 3) != 0)
			it.wanted = 8'($urandom_range(0, 4));
		r = $urandom_range(0, 99);
		if (r < 4) begin
			it.kind = KIND_NONE;
		end else if (r < 4 + tick_pct) begin
			it.kind = KIND_TICK;
		end else if (r < 4 + tick_pct + (96 - tick_pct) / 2) begin
			it.kind = KIND_SUBMIT;
		end else begin
			it.kind = KIND_ACK;
			if (fill != 0 && $urandom_range(0, 9) < 7)
				it.cmd = slots[$urandom_range(0, fill - 1)].cmd;
			r = $urandom_range(0, 9);
			if (r != 9) begin
				it.tsys = own_sys;
				it.tcomp = own_comp;
			end
			if (r == 7)
				it.tsys = 8'($urandom);
			if (r == 8)
				it.tcomp = 8'($urandom);
		end
	endtask

	function automatic link_item_t mk_item(logic [1:0] k, logic [15:0] cmd, logic [7:0] tag,
			logic [7:0] wanted, logic [7:0] tsys, logic [7:0] tcomp, logic [7:0] code);
		link_item_t it;
		it.kind = k;
		it.cmd = cmd;
		it.tag = tag;
		it.wanted = wanted;
		it.tsys = tsys;
		it.tcomp = tcomp;
		it.code = code;
		return it;
	endfunction

	function automatic result_t mk_res(logic [2:0] ev, logic [15:0] cmd, logic [7:0] tag,
			logic [7:0] sends, logic [7:0] conf, logic [7:0] code);
		result_t r;
		r.ev = ev;
		r.cmd = cmd;
		r.tag = tag;
		r.sends = sends;
		r.conf = conf;
		r.code = code;
		return r;
	endfunction

	task automatic add_row(link_item_t it, bit typed, result_t want);
		plan_row_t row;
		row.it = it;
		row.want = want;
		row.typed = typed;
		plan = {plan, row};
	endtask

	always @(posedge clk) begin : watch_results
		outcome_t o;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with none expected, event", 16'(event_res), 16'd0);
			end else begin
				o = pending_results.pop_front();
				check_field("event_res", 16'(event_res), 16'(o.res.ev));
				check_field("out_command_id", out_command_id, o.res.cmd);
				check_field("out_payload_tag", 16'(out_payload_tag), 16'(o.res.tag));
				check_field("sends_done", 16'(sends_done), 16'(o.res.sends));
				check_field("confirmation", 16'(confirmation), 16'(o.res.conf));
				check_field("out_ack_code", 16'(out_ack_code), 16'(o.res.code));
				check_field("last", 16'(last), 16'(o.lst));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : main
		link_item_t it;
		bit         steady;
		int         ph;

		add_row(mk_item(KIND_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_item(KIND_ACK, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA), 1'b1,
			mk_res(RES_IGNORED, 16'h1234, 8'h00, 8'd0, 8'd0, 8'hAA));
		add_row(mk_item(KIND_SUBMIT, 16'h0000, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'h0000, 8'h00, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
			mk_res(RES_FIRST, 16'hFFFF, 8'hFF, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'h5555, 8'hA5, 8'd2, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'h5555, 8'hA5, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'hAAAA, 8'h5A, 8'd1, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'hAAAA, 8'h5A, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'h5555, 8'h11, 8'd3, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'h5555, 8'h11, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'h0101, 8'h01, 8'd0, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'h0101, 8'h01, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'h0202, 8'h02, 8'd1, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'h0202, 8'h02, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'h0303, 8'h03, 8'd2, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FIRST, 16'h0303, 8'h03, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_SUBMIT, 16'hBEEF, 8'h77, 8'd5, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_FULL, 16'hBEEF, 8'h77, 8'd0, 8'd0, 8'h00));
		add_row(mk_item(KIND_ACK, 16'h5555, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01), 1'b1,
			mk_res(RES_IGNORED, 16'h5555, 8'h00, 8'd0, 8'd0, 8'h01));
		add_row(mk_item(KIND_ACK, 16'h5555, 8'h00, 8'h00, 8'h00, 8'h80, 8'h02), 1'b1,
			mk_res(RES_IGNORED, 16'h5555, 8'h00, 8'd0, 8'd0, 8'h02));
		add_row(mk_item(KIND_ACK, 16'h5555, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF), 1'b1,
			mk_res(RES_ACKED, 16'h5555, 8'hA5, 8'd1, 8'd0, 8'hFF));
		add_row(mk_item(KIND_ACK, 16'h0303, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(RES_ACKED, 16'h0303, 8'h03, 8'd1, 8'd0, 8'h00));
		add_row(mk_item(KIND_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
		// age past the reset timeout: resends mixed with back-to-back drops
		repeat (6) begin
			add_row(mk_item(KIND_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0,
				'0);
		end
		add_row(mk_item(KIND_SUBMIT, 16'h4242, 8'h42, 8'd1, 8'h00, 8'h00, 8'h00), 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < plan.size(); n++) begin
			push_item(plan[n].it, plan[n].typed, plan[n].want);
			idle_for(pick_gap(1'b0));
		end
		settle();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_config(8'h00, 8'h00, 8'd1);
				1: write_config(8'hFF, 8'hFF, 8'hFF);
				default: write_config(8'($urandom), 8'($urandom),
					8'($urandom_range(1, 4 * ph - 4)));
			endcase
			steady = (ph == 2);
			repeat (19) begin
				roll_item(it, 30);
				push_item(it, 1'b0, '0);
				if ($urandom_range(0, 19) == 0)
					settle();
				else
					idle_for(pick_gap(steady));
			end
			settle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
